/* design/hcbd_pkg.sv */
// Shared types and character constants for the chunked body decoder.
package hcbd_pkg;

    // Character codes used by the size line parser
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Bytes dropped after each chunk's data
    localparam logic [1:0] TRAILER_BYTES = 2'd2;

    // One body byte as it enters the decoder
    typedef struct packed {
        logic       start_of_body;
        logic [7:0] body_byte;
    } in_item_t;

    // One decoded result
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_last;
        logic       body_complete;
    } result_t;

    // Decoded hex character
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end
        else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

/* design/hcbd_in_reg.sv */
// Input register stage: holds one accepted body byte until the decoder takes it.
module hcbd_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  hcbd_pkg::in_item_t s_item,
    output logic               item_valid,
    output hcbd_pkg::in_item_t item,
    input  logic               item_take
);

    logic               valid_reg;
    hcbd_pkg::in_item_t item_reg;

    // Accept whenever the held item is empty or leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // Capture the payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

/* design/hcbd_core.sv */
// Chunk framing state machine with its result register.
module hcbd_core #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  hcbd_pkg::in_item_t item,
    output logic               item_take,
    output logic               res_valid,
    output hcbd_pkg::result_t  res,
    input  logic               res_ready
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_DATA,
        PH_SKIP,
        PH_FINAL,
        PH_DONE
    } phase_t;

    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;

    phase_t                phase_reg, phase_next, phase_cur;
    logic [SIZE_WIDTH-1:0] size_accum_reg, size_accum_next, size_accum_cur;
    logic [SIZE_WIDTH-1:0] bytes_left_reg, bytes_left_next, bytes_left_cur;
    logic                  saw_cr_reg, saw_cr_next, saw_cr_cur;
    logic                  digits_ended_reg, digits_ended_next, digits_ended_cur;
    logic [1:0]            skip_count_reg, skip_count_next, skip_count_cur;
    logic                  res_valid_reg;
    hcbd_pkg::result_t     res_reg, res_next;
    hcbd_pkg::hex_t        hex;
    logic [7:0]            c;
    logic                  blank;
    logic                  line_end;
    logic [1:0]            skip_dec;

    // Take the held byte when the result register is free or drains now
    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign c        = item.body_byte;
    assign hex      = hcbd_pkg::hex_decode(c);
    assign line_end = (c == hcbd_pkg::CHAR_LF) && saw_cr_cur;
    assign skip_dec = (skip_count_cur != 2'd0) ? skip_count_cur - 2'd1 : 2'd0;

    always_comb
    begin
        blank = c inside {hcbd_pkg::CHAR_SPACE, hcbd_pkg::CHAR_TAB, hcbd_pkg::CHAR_LF,
                          hcbd_pkg::CHAR_VT, hcbd_pkg::CHAR_FF, hcbd_pkg::CHAR_CR};
    end

    // Start of body restarts the size line before this byte is decoded
    always_comb
    begin
        if (item.start_of_body)
        begin
            phase_cur        = PH_LEAD;
            size_accum_cur   = '0;
            bytes_left_cur   = '0;
            saw_cr_cur       = 1'b0;
            digits_ended_cur = 1'b0;
            skip_count_cur   = 2'd0;
        end
        else
        begin
            phase_cur        = phase_reg;
            size_accum_cur   = size_accum_reg;
            bytes_left_cur   = bytes_left_reg;
            saw_cr_cur       = saw_cr_reg;
            digits_ended_cur = digits_ended_reg;
            skip_count_cur   = skip_count_reg;
        end
    end

    // Decode one byte against the framing state
    always_comb
    begin
        phase_next        = phase_cur;
        size_accum_next   = size_accum_cur;
        bytes_left_next   = bytes_left_cur;
        saw_cr_next       = saw_cr_cur;
        digits_ended_next = digits_ended_cur;
        skip_count_next   = skip_count_cur;
        res_next          = '0;
        case (phase_cur)
            PH_LEAD, PH_DIGITS:
            begin
                if (line_end)
                begin
                    // Close the size line: zero size means the last chunk
                    saw_cr_next       = 1'b0;
                    digits_ended_next = 1'b0;
                    if (size_accum_cur == '0)
                    begin
                        phase_next = PH_FINAL;
                    end
                    else
                    begin
                        bytes_left_next = size_accum_cur;
                        phase_next      = PH_DATA;
                    end
                end
                else
                begin
                    saw_cr_next = (c == hcbd_pkg::CHAR_CR);
                    if (phase_cur == PH_LEAD)
                    begin
                        if (!blank)
                        begin
                            phase_next = PH_DIGITS;
                            if (hex.is_hex)
                            begin
                                size_accum_next = SIZE_WIDTH'(hex.value);
                            end
                            else
                            begin
                                digits_ended_next = 1'b1;
                            end
                        end
                    end
                    else if (!digits_ended_cur)
                    begin
                        if (!hex.is_hex)
                        begin
                            digits_ended_next = 1'b1;
                        end
                        else if (|size_accum_cur[SIZE_WIDTH-1 -: 4])
                        begin
                            // Saturate once another digit would overflow
                            size_accum_next = SIZE_MAX;
                        end
                        else
                        begin
                            size_accum_next = {size_accum_cur[SIZE_WIDTH-5:0], hex.value};
                        end
                    end
                end
            end
            PH_DATA:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = c;
                if (~|bytes_left_cur[SIZE_WIDTH-1:1])
                begin
                    bytes_left_next     = '0;
                    res_next.chunk_last = 1'b1;
                    phase_next          = PH_SKIP;
                    skip_count_next     = hcbd_pkg::TRAILER_BYTES;
                end
                else
                begin
                    bytes_left_next = bytes_left_cur - SIZE_WIDTH'(1);
                end
            end
            PH_SKIP:
            begin
                // Drop the trailer bytes, then open a new size line
                skip_count_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    phase_next        = PH_LEAD;
                    size_accum_next   = '0;
                    bytes_left_next   = '0;
                    saw_cr_next       = 1'b0;
                    digits_ended_next = 1'b0;
                end
            end
            PH_FINAL:
            begin
                if (line_end)
                begin
                    saw_cr_next            = 1'b0;
                    res_next.body_complete = 1'b1;
                    phase_next             = PH_DONE;
                end
                else
                begin
                    saw_cr_next = (c == hcbd_pkg::CHAR_CR);
                end
            end
            default:
            begin
                // Completed: ignore bytes until the next start of body
            end
        endcase
    end

    // Hold framing state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEAD;
            size_accum_reg   <= '0;
            bytes_left_reg   <= '0;
            saw_cr_reg       <= 1'b0;
            digits_ended_reg <= 1'b0;
            skip_count_reg   <= 2'd0;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
        end
        else
        begin
            if (item_take)
            begin
                phase_reg        <= phase_next;
                size_accum_reg   <= size_accum_next;
                bytes_left_reg   <= bytes_left_next;
                saw_cr_reg       <= saw_cr_next;
                digits_ended_reg <= digits_ended_next;
                skip_count_reg   <= skip_count_next;
                res_reg          <= res_next;
            end
            if (item_take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // A chunk end marker only rides on a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.chunk_last |-> res_reg.payload_valid)
    else $error("chunk_last without payload_valid");

    // Payload and completion never share one result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.payload_valid && res_reg.body_complete))
    else $error("payload and completion in one result");

    // Completion moves the decoder into its finished phase
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && res_next.body_complete |=> phase_reg == PH_DONE)
    else $error("completion without entering the finished phase");

    // Once finished, bytes give all-zero results until a restart
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && phase_cur == PH_DONE |=> res_valid_reg && res_reg == '0)
    else $error("non-zero result after completion");

    // A byte taken in the data phase comes out as payload
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && phase_cur == PH_DATA |=> res_valid_reg && res_reg.payload_valid)
    else $error("data byte not passed out");

endmodule

/* design/http_chunked_body_decoder.sv */
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Takes the message body one byte per transaction and produces exactly one result per
// byte: payload bytes are flagged and the last byte of each chunk carries tlast, size
// lines, chunk trailers and everything after the terminating line give empty results,
// and the LF that ends the terminating line raises body_complete. Raise start_of_body
// with the first byte of a new body. One byte is taken every clock cycle unless the
// decoder stalls; each byte passes an input register and then one decode step into the
// result register, which presents its result. While a result waits for the downstream
// side the decoder stalls: the input register takes at most one more byte and then holds
// s_axis_tready low. SIZE_WIDTH sets the chunk size counter; larger sizes saturate at its
// maximum.
module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
    input  logic [0:0] s_axis_tuser,   // [0] start_of_body
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // chunk_last
    output logic [1:0] m_axis_tuser    // [0] payload_valid, [1] body_complete
);

    hcbd_pkg::in_item_t s_item;
    hcbd_pkg::in_item_t item;
    hcbd_pkg::result_t  res;
    logic               item_valid;
    logic               item_take;

    // Pack the slave-side transaction
    assign s_item.body_byte     = s_axis_tdata;
    assign s_item.start_of_body = s_axis_tuser[0];

    hcbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hcbd_core #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .res_ready  (m_axis_tready)
    );

    // Unpack the result onto the master side
    assign m_axis_tdata = res.payload_byte;
    assign m_axis_tlast = res.chunk_last;
    assign m_axis_tuser = {res.body_complete, res.payload_valid};

endmodule

/* test/hcbd_stream_checker.sv */
// Stream checker for the chunked body decoder: predicts each result and compares it.
module hcbd_stream_checker #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic [0:0] s_axis_tuser,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [1:0] m_axis_tuser,
    output int         fail_count,
    output int         results_waiting,
    output int         results_checked,
    output int         bodies_done
);

    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;

    typedef enum logic [2:0] {
        SZ_LEAD,
        SZ_DIGITS,
        CHUNK_DATA,
        TRAILER_SKIP,
        LAST_LINE,
        BODY_DONE
    } dec_phase_t;

    // Predicted decoder state
    dec_phase_t            phase_q;
    logic [SIZE_WIDTH-1:0] size_acc;
    logic [SIZE_WIDTH-1:0] data_left;
    logic                  cr_seen;
    logic                  digits_done;
    logic [1:0]            trailer_left;

    hcbd_pkg::result_t  pending_results[$];
    hcbd_pkg::result_t  want;
    hcbd_pkg::result_t  got;
    hcbd_pkg::in_item_t taken;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic is_size_blank(input logic [7:0] c);
        return c == hcbd_pkg::CHAR_SPACE || c == hcbd_pkg::CHAR_TAB ||
               c == hcbd_pkg::CHAR_LF || c == hcbd_pkg::CHAR_VT ||
               c == hcbd_pkg::CHAR_FF || c == hcbd_pkg::CHAR_CR;
    endfunction

    task automatic open_size_line();
        phase_q      = SZ_LEAD;
        size_acc     = '0;
        data_left    = '0;
        cr_seen      = 1'b0;
        digits_done  = 1'b0;
        trailer_left = 2'd0;
    endtask

    // Advance the predicted state by one body byte and give its result
    task automatic decode_byte(input hcbd_pkg::in_item_t item,
                               output hcbd_pkg::result_t res);
        logic [7:0] c;
        logic [4:0] h;
        c   = item.body_byte;
        res = '0;
        if (item.start_of_body)
            open_size_line();
        h = hex_digit(c);
        case (phase_q)
            SZ_LEAD, SZ_DIGITS: begin
                if (c == hcbd_pkg::CHAR_LF && cr_seen) begin
                    // Line end: zero size goes to the terminating line
                    cr_seen     = 1'b0;
                    digits_done = 1'b0;
                    if (size_acc == '0) begin
                        phase_q = LAST_LINE;
                    end
                    else begin
                        data_left = size_acc;
                        phase_q   = CHUNK_DATA;
                    end
                end
                else begin
                    cr_seen = (c == hcbd_pkg::CHAR_CR);
                    if (phase_q == SZ_LEAD) begin
                        if (!is_size_blank(c)) begin
                            phase_q = SZ_DIGITS;
                            if (h[4])
                                size_acc = SIZE_WIDTH'(h[3:0]);
                            else
                                digits_done = 1'b1;
                        end
                    end
                    else if (!digits_done) begin
                        if (!h[4])
                            digits_done = 1'b1;
                        else if (size_acc > (SIZE_MAX >> 4))
                            size_acc = SIZE_MAX;
                        else
                            size_acc = (size_acc << 4) | SIZE_WIDTH'(h[3:0]);
                    end
                end
            end
            CHUNK_DATA: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = c;
                if (data_left <= 1) begin
                    data_left      = '0;
                    res.chunk_last = 1'b1;
                    phase_q        = TRAILER_SKIP;
                    trailer_left   = hcbd_pkg::TRAILER_BYTES;
                end
                else begin
                    data_left = data_left - SIZE_WIDTH'(1);
                end
            end
            TRAILER_SKIP: begin
                if (trailer_left > 0)
                    trailer_left = trailer_left - 2'd1;
                if (trailer_left == 0)
                    open_size_line();
            end
            LAST_LINE: begin
                if (c == hcbd_pkg::CHAR_LF && cr_seen) begin
                    cr_seen           = 1'b0;
                    res.body_complete = 1'b1;
                    phase_q           = BODY_DONE;
                end
                else begin
                    cr_seen = (c == hcbd_pkg::CHAR_CR);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, name, want_v, got_v);
        end
    endtask

    // Compare each result transaction, then predict each byte transaction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            open_size_line();
            pending_results.delete();
            fail_count      = 0;
            results_waiting = 0;
            results_checked = 0;
            bodies_done     = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.payload_valid = m_axis_tuser[0];
                got.payload_byte  = m_axis_tdata;
                got.chunk_last    = m_axis_tlast;
                got.body_complete = m_axis_tuser[1];
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, got);
                end
                else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(got.payload_valid));
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("chunk_last", 8'(want.chunk_last), 8'(got.chunk_last));
                    check_field("body_complete", 8'(want.body_complete),
                                8'(got.body_complete));
                    if (want.body_complete)
                        bodies_done++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                taken.start_of_body = s_axis_tuser[0];
                taken.body_byte     = s_axis_tdata;
                decode_byte(taken, want);
                pending_results.push_back(want);
            end
            results_waiting = pending_results.size();
        end
    end

endmodule

/* test/tb_http_chunked_body_decoder.sv */
// Testbench top for the chunked body decoder: stimulus, flow control and verdict.
module tb_http_chunked_body_decoder;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic [0:0] s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    int fail_count;
    int results_waiting;
    int results_checked;
    int bodies_done;
    int cycle_count = 0;
    int sink_hold   = 0;
    int sink_calm   = 0;

    hcbd_pkg::in_item_t body_stream[$];
    logic               start_pending = 1'b0;

    http_chunked_body_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    hcbd_stream_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked),
        .bodies_done     (bodies_done)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Queue one body byte; the first byte after a restart request carries start_of_body
    task automatic push_byte(input logic [7:0] b);
        hcbd_pkg::in_item_t item;
        item.body_byte     = b;
        item.start_of_body = start_pending;
        start_pending      = 1'b0;
        body_stream.push_back(item);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return "0" + 8'(v);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
    endfunction

    // Queue a size line: blanks, digits with pad leading zeros, optional extension, CR LF
    task automatic push_size_line(input logic [31:0] size, input int pad);
        logic [7:0] blanks[5] = '{hcbd_pkg::CHAR_SPACE, hcbd_pkg::CHAR_TAB,
                                  hcbd_pkg::CHAR_VT, hcbd_pkg::CHAR_FF,
                                  hcbd_pkg::CHAR_LF};
        int ndig;
        int k;
        ndig = 0;
        for (k = 0; k < 8; k++)
            if ((size >> (4 * k)) != 0)
                ndig = k + 1;
        ndig += pad;
        repeat ($urandom_range(0, 2))
            push_byte(blanks[$urandom_range(0, 4)]);
        for (k = ndig - 1; k >= 0; k--)
            push_byte(hex_char(4'(size >> (4 * k))));
        if ($urandom_range(0, 3) == 0) begin
            push_byte(";");
            repeat ($urandom_range(0, 4))
                push_byte(8'($urandom_range(33, 126)));
        end
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
    endtask

    // Build the whole byte stream: directed bodies first, then random ones
    task automatic build_stream();
        int kind;
        int size;
        // Blanks and extension, one-byte chunk, empty terminator, byte after completion
        start_pending = 1'b1;
        push_byte(" ");
        push_byte("1");
        push_byte(";");
        push_byte("z");
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(8'h00);
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(8'hFF);
        // Non-hex first byte reads as size zero
        start_pending = 1'b1;
        push_byte("x");
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        // Restart before the trailer of a chunk whose data holds 0xFF and CR
        start_pending = 1'b1;
        push_byte("2");
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
        push_byte(8'hFF);
        push_byte(hcbd_pkg::CHAR_CR);

        while (body_stream.size() < 24 + RANDOM_ITEMS) begin
            kind          = $urandom_range(0, 99);
            start_pending = 1'b1;
            if (kind < 78) begin
                // Well-formed body with random chunk sizes and content
                repeat ($urandom_range(0, 4)) begin
                    size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                       : $urandom_range(1, 12);
                    push_size_line(size, ($urandom_range(0, 3) == 0) ? 1 : 0);
                    repeat (size)
                        push_byte(8'($urandom));
                    if ($urandom_range(0, 7) == 0) begin
                        push_byte(8'($urandom));
                        push_byte(8'($urandom));
                    end
                    else begin
                        push_byte(hcbd_pkg::CHAR_CR);
                        push_byte(hcbd_pkg::CHAR_LF);
                    end
                end
                push_size_line(0, $urandom_range(0, 2));
                repeat ($urandom_range(0, 3))
                    push_byte(8'($urandom_range(33, 126)));
                push_byte(hcbd_pkg::CHAR_CR);
                push_byte(hcbd_pkg::CHAR_LF);
                repeat ($urandom_range(0, 3))
                    push_byte(8'($urandom));
            end
            else if (kind < 88) begin
                // Raw noise with the odd restart
                if ($urandom_range(0, 1))
                    start_pending = 1'b0;
                repeat ($urandom_range(4, 30)) begin
                    if ($urandom_range(0, 15) == 0)
                        start_pending = 1'b1;
                    push_byte(8'($urandom));
                end
            end
            else if (kind < 94) begin
                // Oversized size saturates; the body is cut short by the next restart
                push_byte(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 11))
                    push_byte(hex_char(4'($urandom)));
                push_byte(hcbd_pkg::CHAR_CR);
                push_byte(hcbd_pkg::CHAR_LF);
                repeat ($urandom_range(5, 30))
                    push_byte(8'($urandom));
            end
            else begin
                // Truncated chunk
                size = $urandom_range(4, 20);
                push_size_line(size, 0);
                repeat ($urandom_range(0, size - 1))
                    push_byte(8'($urandom));
            end
        end
    endtask

    // Result side: random stalls, mostly short, with calm stretches
    always @(posedge clk) begin
        int r;
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end
        else begin
            m_axis_tready <= 1'b1;
            if (sink_calm > 0) begin
                sink_calm--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    sink_hold = $urandom_range(1, 3);
                else if (r < 18)
                    sink_hold = $urandom_range(8, 30);
                else if (r == 99)
                    sink_calm = $urandom_range(50, 200);
            end
        end
    end

    // Abort on a run that never finishes
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive the byte stream and give the verdict
    initial begin
        int gap;
        int r;
        int send_calm;
        send_calm = 0;
        build_stream();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        foreach (body_stream[i]) begin
            if (send_calm > 0) begin
                send_calm--;
                gap = 0;
            end
            else begin
                r   = $urandom_range(0, 99);
                gap = 0;
                if (r >= 55 && r < 88)
                    gap = $urandom_range(1, 3);
                else if (r >= 88 && r < 97)
                    gap = $urandom_range(4, 24);
                else if (r >= 97)
                    send_calm = $urandom_range(40, 160);
            end
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= body_stream[i].body_byte;
            s_axis_tuser  <= body_stream[i].start_of_body;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d body bytes in directed and random bodies; %0d results compared.",
                 body_stream.size(), results_checked);
        $display("%0d bodies completed, with saturated sizes, extensions, noise and restarts.",
                 bodies_done);
        if (results_waiting != 0)
            $display("%0d expected results never arrived", results_waiting);
        if (fail_count == 0 && results_waiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/hcbd_pkg.sv
design/hcbd_in_reg.sv
design/hcbd_core.sv
design/http_chunked_body_decoder.sv
test/hcbd_stream_checker.sv
test/tb_http_chunked_body_decoder.sv
